// ===== rtl/htlm_pkg.sv =====
// shared types and constants for the hierarchical tree lock manager
package htlm_pkg;

   localparam int NODES  = 64;
   localparam int IDX_W  = $clog2(NODES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int USER_W = 16;
   localparam int BR_W   = 5;
   localparam int R_W    = BR_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BR_W-1:0]  BRANCHING_RESET  = BR_W'(2);
   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(64);

   typedef enum logic [0:0] {
      REG_BRANCHING  = 1'b0,
      REG_NODE_COUNT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_LOCK    = 2'd0,
      ACT_UNLOCK  = 2'd1,
      ACT_UPGRADE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic done;       // one-cycle pulse, flags below are final
      logic anc;        // a strict ancestor of the target is held
      logic desc;       // some descendant of the target is held
      logic foreign;    // a held descendant belongs to another user
      logic match;      // holder of the target equals the user
   } scan_status_type;

endpackage

// ===== rtl/htlm_ram.sv =====
// generic single-port-write, registered-read ram
module htlm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/htlm_scan.sv =====
// node sweep: walks the nodes in use in order, tracks parents and ancestry flags
module htlm_scan
   import htlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IDX_W-1:0]      target,
   input  logic [USER_W-1:0]     user,
   input  logic [BR_W-1:0]       fan_out,
   input  logic [CNT_W-1:0]      used,
   input  logic [NODES-1:0]      held,
   output logic [IDX_W-1:0]      rd_addr,
   input  logic [USER_W-1:0]     rd_data,
   output logic [NODES-1:0]      below_vec,
   output scan_status_type       status
);

   logic [CNT_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] p_ff, p_in;
   logic [R_W-1:0]   r_ff, r_in;
   logic             run_ff, run_in;
   logic             tail_ff, tail_in;
   logic             done_ff, done_in;
   logic [NODES-1:0] abv_ff, abv_in;
   logic [NODES-1:0] dsc_ff, dsc_in;
   logic             anc_ff, anc_in;
   logic             desc_ff, desc_in;
   logic             foreign_ff, foreign_in;
   logic             match_ff, match_in;
   logic             chk_ff, chk_in;
   logic             hit_ff, hit_in;

   logic [IDX_W-1:0] kk;
   logic             a_k, d_k;
   logic [CNT_W-1:0] k_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         tail_ff <= 1'b0;
         done_ff <= 1'b0;
         chk_ff  <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         run_ff  <= run_in;
         tail_ff <= tail_in;
         done_ff <= done_in;
         chk_ff  <= chk_in;
         hit_ff  <= hit_in;
      end
      k_ff       <= k_in;
      p_ff       <= p_in;
      r_ff       <= r_in;
      abv_ff     <= abv_in;
      dsc_ff     <= dsc_in;
      anc_ff     <= anc_in;
      desc_ff    <= desc_in;
      foreign_ff <= foreign_in;
      match_ff   <= match_in;
   end

   always_comb begin
      kk     = k_ff[IDX_W-1:0];
      k_next = k_ff + CNT_W'(1);
      // node zero is the root and has no parent
      if (kk == '0) begin
         a_k = 1'b0;
         d_k = 1'b0;
      end else begin
         a_k = held[p_ff] | abv_ff[p_ff];
         d_k = (p_ff == target) | dsc_ff[p_ff];
      end

      k_in       = k_ff;
      p_in       = p_ff;
      r_in       = r_ff;
      run_in     = run_ff;
      tail_in    = 1'b0;
      done_in    = tail_ff;
      abv_in     = abv_ff;
      dsc_in     = dsc_ff;
      anc_in     = anc_ff;
      desc_in    = desc_ff;
      foreign_in = foreign_ff;
      match_in   = match_ff;
      chk_in     = 1'b0;
      hit_in     = 1'b0;

      // compare stage, in the cycle after the sweep step, to meet the registered ram read
      if (chk_ff && (rd_data != user)) begin
         foreign_in = 1'b1;
      end
      if (hit_ff) begin
         match_in = (rd_data == user);
      end

      if (start) begin
         k_in       = '0;
         p_in       = '0;
         r_in       = '0;
         run_in     = 1'b1;
         abv_in     = '0;
         dsc_in     = '0;
         anc_in     = 1'b0;
         desc_in    = 1'b0;
         foreign_in = 1'b0;
         match_in   = 1'b0;
      end else if (run_ff) begin
         abv_in[kk] = a_k;
         dsc_in[kk] = d_k;
         if (kk == target) begin
            anc_in = a_k;
         end
         if (held[kk] && d_k) begin
            desc_in = 1'b1;
         end
         chk_in = held[kk] & d_k;
         hit_in = (kk == target);
         // parent of the next node: step the child slot, roll into the next parent
         if (kk != '0) begin
            if ({1'b0, r_ff} + (R_W+1)'(1) == {1'b0, fan_out}) begin
               r_in = '0;
               p_in = p_ff + IDX_W'(1);
            end else begin
               r_in = r_ff + R_W'(1);
            end
         end
         k_in = k_next;
         if (k_next == used) begin
            run_in  = 1'b0;
            tail_in = 1'b1;
         end
      end
   end

   assign rd_addr   = kk;
   assign below_vec = dsc_ff;

   assign status.done    = done_ff;
   assign status.anc     = anc_ff;
   assign status.desc    = desc_ff;
   assign status.foreign = foreign_ff;
   assign status.match   = match_ff;

endmodule

// ===== rtl/hierarchical_tree_lock_manager.sv =====
// lock manager over a complete m-ary tree of nodes, top level
// flow: an accepted word starts the sweep over the nodes in use, then the decision
//   loads the result word; an out-of-range node or unused action skips the sweep
// throughput: one word per request, the next word is taken once the result register is
//   loaded; the sweep visits one node in use per cycle, and a word waits longer only
//   while an earlier result word still waits on rsp_tready
// reset: synchronous, clears all locks and loads branching 2 and node count 64
module hierarchical_tree_lock_manager
   import htlm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: action [1:0], node_index [7:2], user_id [23:8]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,
   // rsp_tdata: granted [0], zero fill [7:1]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   state_type         state_ff, state_in;
   logic [BR_W-1:0]   branching_ff, branching_in;
   logic [CNT_W-1:0]  node_count_ff, node_count_in;
   logic [NODES-1:0]  held_ff, held_in;
   action_type        act_ff, act_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [USER_W-1:0] user_ff, user_in;
   logic              bad_ff, bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              granted_ff, granted_in;

   logic [BR_W-1:0]   fan_out;
   logic [CNT_W-1:0]  used;
   logic              scan_start;
   logic              req_ok;
   logic              ok;
   logic              ram_we;
   logic [IDX_W-1:0]  rd_addr;
   logic [USER_W-1:0] rd_data;
   logic [NODES-1:0]  below_vec;
   scan_status_type   status;
   reg_index_type     csr_reg;
   logic [IDX_W-1:0]  req_node;
   logic [1:0]        req_act;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         branching_ff  <= BRANCHING_RESET;
         node_count_ff <= NODE_COUNT_RESET;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         branching_ff  <= branching_in;
         node_count_ff <= node_count_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      act_ff     <= act_in;
      tgt_ff     <= tgt_in;
      user_ff    <= user_in;
      bad_ff     <= bad_in;
      granted_ff <= granted_in;
   end

   // configuration registers
   assign csr_reg    = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      branching_in  = branching_ff;
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_reg)
            REG_BRANCHING:  branching_in  = csr_pwdata[BR_W-1:0];
            REG_NODE_COUNT: node_count_in = csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
      case (csr_reg)
         REG_BRANCHING:  csr_prdata = CSR_DATA_W'(branching_ff);
         REG_NODE_COUNT: csr_prdata = CSR_DATA_W'(node_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign fan_out = (branching_ff == '0) ? BR_W'(1) : branching_ff;
   assign used    = (node_count_ff > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_ff;

   assign req_node = req_tdata[2 +: IDX_W];
   assign req_act  = req_tdata[1:0];

   always_comb begin
      case (req_act)
         ACT_LOCK, ACT_UNLOCK, ACT_UPGRADE: req_ok = ({1'b0, req_node} < used);
         default:                           req_ok = 1'b0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // decision from the sweep flags
   always_comb begin
      case (act_ff)
         ACT_LOCK:    ok = !held_ff[tgt_ff] && !status.anc && !status.desc;
         ACT_UNLOCK:  ok = held_ff[tgt_ff] && status.match;
         ACT_UPGRADE: ok = !held_ff[tgt_ff] && !status.anc && status.desc && !status.foreign;
         default:     ok = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      act_in       = act_ff;
      tgt_in       = tgt_ff;
      user_in      = user_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      granted_in   = granted_ff;
      scan_start   = 1'b0;
      ram_we       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in  = action_type'(req_act);
               tgt_in  = req_node;
               user_in = req_tdata[8 +: USER_W];
               bad_in  = !req_ok;
               if (req_ok) begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_SCAN: begin
            if (status.done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               granted_in   = !bad_ff && ok;
               state_in     = ST_IDLE;
               if (!bad_ff && ok) begin
                  case (act_ff)
                     ACT_LOCK: begin
                        held_in[tgt_ff] = 1'b1;
                        ram_we          = 1'b1;
                     end
                     ACT_UNLOCK: begin
                        held_in[tgt_ff] = 1'b0;
                     end
                     ACT_UPGRADE: begin
                        held_in         = held_ff & ~below_vec;
                        held_in[tgt_ff] = 1'b1;
                        ram_we          = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, granted_ff};

   htlm_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .target    (tgt_ff),
      .user      (user_ff),
      .fan_out   (fan_out),
      .used      (used),
      .held      (held_ff),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .below_vec (below_vec),
      .status    (status)
   );

   // holder is only used where held is set, so it needs no clearing
   htlm_ram #(
      .WIDTH (USER_W),
      .DEPTH (NODES)
   ) u_holder (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tgt_ff),
      .wr_data (user_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== dv/htlm_checker.sv =====
// grant predictor and result checker for the tree lock manager testbench
`timescale 1ns / 100ps

module htlm_checker
   import htlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending,
   output int                    grant_count
);

   logic [BR_W-1:0]   fan_reg;
   logic [CNT_W-1:0]  count_reg;
   logic              node_locked [NODES];
   logic [USER_W-1:0] node_owner [NODES];
   logic              grant_queue [$];
   int                mismatches;
   int                grants;
   logic              want_grant;
   logic [7:0]        want_word;
   logic              next_grant;

   function automatic int fan_out();
      return (fan_reg == '0) ? 1 : int'(fan_reg);
   endfunction

   function automatic int nodes_in_use();
      return (count_reg > CNT_W'(NODES)) ? NODES : int'(count_reg);
   endfunction

   // true when a is a strict ancestor of d
   function automatic bit is_ancestor(input int a, input int d, input int m);
      if (d <= a) return 1'b0;
      while (d > a) d = (d - 1) / m;
      return d == a;
   endfunction

   // decides one request against the lock table and applies it when granted
   function automatic logic decide_request(input logic [1:0] act, input int t,
                                           input logic [USER_W-1:0] user);
      int   n;
      int   m;
      int   k;
      logic anc;
      logic desc;
      logic foreign;
      logic ok;
      n = nodes_in_use();
      m = fan_out();
      anc = 1'b0;
      desc = 1'b0;
      foreign = 1'b0;
      ok = 1'b0;
      if (t >= n) return 1'b0;
      for (k = 0; k < n; k++) begin
         if (node_locked[k]) begin
            if (is_ancestor(k, t, m)) anc = 1'b1;
            if (is_ancestor(t, k, m)) begin
               desc = 1'b1;
               if (node_owner[k] != user) foreign = 1'b1;
            end
         end
      end
      case (act)
         ACT_LOCK: begin
            if (!node_locked[t] && !anc && !desc) begin
               node_locked[t] = 1'b1;
               node_owner[t] = user;
               ok = 1'b1;
            end
         end
         ACT_UNLOCK: begin
            if (node_locked[t] && node_owner[t] == user) begin
               node_locked[t] = 1'b0;
               node_owner[t] = '0;
               ok = 1'b1;
            end
         end
         ACT_UPGRADE: begin
            if (!node_locked[t] && !anc && desc && !foreign) begin
               for (k = 0; k < n; k++) begin
                  if (node_locked[k] && is_ancestor(t, k, m)) begin
                     node_locked[k] = 1'b0;
                     node_owner[k] = '0;
                  end
               end
               node_locked[t] = 1'b1;
               node_owner[t] = user;
               ok = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fan_reg = BRANCHING_RESET;
         count_reg = NODE_COUNT_RESET;
         for (int i = 0; i < NODES; i++) begin
            node_locked[i] = 1'b0;
            node_owner[i] = '0;
         end
         grant_queue.delete();
         mismatches = 0;
         grants = 0;
      end else begin
         // result side first: a word accepted now cannot answer itself
         if (rsp_tvalid && rsp_tready) begin
            if (grant_queue.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected, got %02h", $time, rsp_tdata);
            end else begin
               want_grant = grant_queue.pop_front();
               want_word = {7'b0, want_grant};
               if (rsp_tdata !== want_word) begin
                  mismatches++;
                  $display("%0t: result mismatch, expected %02h, got %02h",
                           $time, want_word, rsp_tdata);
               end
               if (rsp_tdata[0] === 1'b1) grants++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_BRANCHING, 2'b00})
               fan_reg = csr_pwdata[BR_W-1:0];
            else if (csr_paddr == {REG_NODE_COUNT, 2'b00})
               count_reg = csr_pwdata[CNT_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            next_grant = decide_request(req_tdata[1:0], int'(req_tdata[7:2]),
                                        req_tdata[23:8]);
            grant_queue = {grant_queue, next_grant};
         end
      end
      fail_count <= mismatches;
      pending <= grant_queue.size();
      grant_count <= grants;
   end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the tree lock manager: stimulus, register phases and verdict
`timescale 1ns / 100ps

module tb_top
   import htlm_pkg::*;
();

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int grant_count;

   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int budget;
   int requests_sent = 0;
   int settings_done = 1;
   int cfg_fan = 2;
   int cfg_used = 64;

   logic [USER_W-1:0] user_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
   int phase_fan   [PHASES] = '{2, 1, 16, 3, 0, 4, 5, 2, 31, 7};
   int phase_count [PHASES] = '{64, 64, 64, 20, 8, 127, 0, 1, 40, 64};
   int phase_items [PHASES] = '{100, 80, 80, 80, 80, 80, 20, 30, 80, 100};

   hierarchical_tree_lock_manager uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   htlm_checker grant_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending),
      .grant_count (grant_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // result side: random stalls plus one long hold-off to back up the block
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rx_idle && $urandom_range(0, 99) < 26);
         end
      end
   end

   function automatic logic [USER_W-1:0] pick_user();
      if ($urandom_range(0, 9) == 0) return USER_W'($urandom_range(0, 65535));
      return user_pool[$urandom_range(0, 3)];
   endfunction

   function automatic int pick_node();
      if (cfg_used == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, NODES - 1);
      return $urandom_range(0, cfg_used - 1);
   endfunction

   task automatic send(input logic [1:0] act, input int node, input logic [USER_W-1:0] user);
      while (tx_idle && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {user, node[IDX_W-1:0], act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      budget--;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits carry noise half of the time, the register keeps only its field
   task automatic apply_setting(input int fan, input int count);
      logic [CSR_DATA_W-1:0] noise;
      noise = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      csr_write(REG_BRANCHING, {noise[CSR_DATA_W-1:BR_W], BR_W'(fan)});
      noise = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      csr_write(REG_NODE_COUNT, {noise[CSR_DATA_W-1:CNT_W], CNT_W'(count)});
      cfg_fan = (fan == 0) ? 1 : fan;
      cfg_used = (count > NODES) ? NODES : count;
      settings_done++;
   endtask

   task automatic random_burst();
      int kind;
      int t;
      int c;
      int x;
      logic [USER_W-1:0] user;
      kind = $urandom_range(0, 99);
      user = pick_user();
      if (kind < 40 && cfg_used > 0) begin
         // lock some children for one user, then try to fold them into the parent
         t = $urandom_range(0, cfg_used - 1);
         for (c = 1; c <= cfg_fan && c <= 3; c++) begin
            x = t * cfg_fan + c;
            if (x < cfg_used && $urandom_range(0, 3) != 0) send(ACT_LOCK, x, user);
         end
         if ($urandom_range(0, 4) == 0) send(ACT_LOCK, pick_node(), pick_user());
         send(ACT_UPGRADE, t, user);
         if ($urandom_range(0, 1) == 1) send(ACT_UNLOCK, t, user);
      end else if (kind < 65) begin
         t = pick_node();
         send(ACT_LOCK, t, user);
         if ($urandom_range(0, 2) == 0) send(ACT_LOCK, pick_node(), pick_user());
         send(ACT_UNLOCK, t, ($urandom_range(0, 5) == 0) ? pick_user() : user);
      end else if (kind < 90) begin
         send(2'($urandom_range(0, 3)), pick_node(), user);
      end else begin
         repeat (4) send(ACT_UNLOCK, pick_node(), pick_user());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset setting: binary tree of 64 nodes
      send(ACT_LOCK, 63, 16'hFFFF);
      send(ACT_LOCK, 0, 16'h0000);
      send(ACT_LOCK, 31, 16'h0000);
      send(ACT_UNLOCK, 63, 16'h0000);
      send(ACT_UNLOCK, 63, 16'hFFFF);
      send(ACT_UNUSED, 5, 16'hFFFF);
      send(ACT_LOCK, 3, 16'hFFFF);
      send(ACT_LOCK, 4, 16'hFFFF);
      send(ACT_UPGRADE, 1, 16'h0000);
      send(ACT_UPGRADE, 2, 16'hFFFF);
      send(ACT_UPGRADE, 1, 16'hFFFF);
      send(ACT_UPGRADE, 1, 16'hFFFF);
      send(ACT_LOCK, 9, 16'hFFFF);
      send(ACT_UPGRADE, 4, 16'hFFFF);
      send(ACT_UNLOCK, 1, 16'h0000);
      send(ACT_LOCK, 1, 16'hFFFF);
      send(ACT_UNLOCK, 1, 16'hFFFF);
      send(ACT_LOCK, 62, 16'h5A5A);
      send(ACT_LOCK, 61, 16'hFFFF);
      send(ACT_UPGRADE, 0, 16'hFFFF);
      send(ACT_UNLOCK, 62, 16'h5A5A);
      send(ACT_UPGRADE, 0, 16'hFFFF);
      send(ACT_UNUSED, 63, 16'hA5A5);
      send(ACT_UNLOCK, 0, 16'hFFFF);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) apply_setting(phase_fan[p], phase_count[p]);
         // a stretch with no idling on either side
         tx_idle = (p != 2);
         rx_idle = (p != 2);
         if (p == 1) hold_request = 1'b1;
         budget = phase_items[p];
         while (budget > 0) random_burst();
         settle();
      end

      repeat (80) @(posedge clock);
      $display("tb: %0d requests over %0d register settings, %0d granted",
               requests_sent, settings_done, grant_count);
      $display("tb: branching 0 to 31, node counts 0 to 127, one long result stall");
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/htlm_pkg.sv
rtl/htlm_ram.sv
rtl/htlm_scan.sv
rtl/hierarchical_tree_lock_manager.sv
dv/htlm_checker.sv
dv/tb_top.sv
